[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Same, on the clk and rst_n in scope
`define ASSERT_STD(lbl, prop) `ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

[hw/rtl/swgo_pkg.sv]
// Constants, CORDIC arctangent table and register indexes for the odometry block.
// No dependencies.
package swgo_pkg;

    localparam int MaxIter = 24;
    localparam int IterW   = 5;
    localparam int WordW   = 35;
    localparam int ProdW   = 2 * WordW;

    localparam logic signed [WordW-1:0] PiQ29     = 35'sd1686629713;
    localparam logic signed [WordW-1:0] HalfPiQ29 = 35'sd843314857;
    localparam logic signed [WordW-1:0] GainQ30   = 35'sd652032874;
    localparam logic signed [18:0]      PiQ13     = 19'sd25736;
    localparam logic signed [18:0]      TwoPiQ13  = 19'sd51472;

    typedef enum logic [1:0] {
        REG_SPEED_SCALE  = 2'd0,
        REG_TIME_STEP    = 2'd1,
        REG_ANGLE_NEGATE = 2'd2
    } reg_idx_t;

    function automatic logic signed [WordW-1:0] atan_q29(input logic [IterW-1:0] i);
        logic signed [WordW-1:0] r;
        case (i)
            5'd0:    r = 35'sd421657428;
            5'd1:    r = 35'sd248918915;
            5'd2:    r = 35'sd131521918;
            5'd3:    r = 35'sd66762579;
            5'd4:    r = 35'sd33510843;
            5'd5:    r = 35'sd16771758;
            5'd6:    r = 35'sd8387925;
            5'd7:    r = 35'sd4194219;
            5'd8:    r = 35'sd2097141;
            5'd9:    r = 35'sd1048575;
            5'd10:   r = 35'sd524288;
            5'd11:   r = 35'sd262144;
            5'd12:   r = 35'sd131072;
            5'd13:   r = 35'sd65536;
            5'd14:   r = 35'sd32768;
            5'd15:   r = 35'sd16384;
            5'd16:   r = 35'sd8192;
            5'd17:   r = 35'sd4096;
            5'd18:   r = 35'sd2048;
            5'd19:   r = 35'sd1024;
            5'd20:   r = 35'sd512;
            5'd21:   r = 35'sd256;
            5'd22:   r = 35'sd128;
            5'd23:   r = 35'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/swgo_in_if.sv]
// Sensor request channel: valid/ready plus encoder, steering and gyro fields.
// No dependencies.
interface swgo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rear_left_count;
    logic signed [15:0] rear_right_count;
    logic signed [15:0] rear_left_angle;
    logic signed [15:0] rear_right_angle;
    logic signed [15:0] gyro_rate;

    modport source (output valid, rear_left_count, rear_right_count, rear_left_angle,
                    rear_right_angle, gyro_rate, input ready);
    modport sink   (input valid, rear_left_count, rear_right_count, rear_left_angle,
                    rear_right_angle, gyro_rate, output ready);
endinterface

[hw/rtl/swgo_out_if.sv]
// Odometry result channel: valid/ready plus velocity, position, heading, quaternion.
// No dependencies.
interface swgo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               in_place_rotation;

    modport source (output valid, vel_x, vel_y, pos_x, pos_y, heading, quat_z, quat_w,
                    in_place_rotation, input ready);
    modport sink   (input valid, vel_x, vel_y, pos_x, pos_y, heading, quat_z, quat_w,
                    in_place_rotation, output ready);
endinterface

[hw/rtl/steered_wheel_gyro_odometry.sv]
// Steered-wheel odometry with gyro heading: sequencer, shared multiplier and CORDIC.
// Depends on swgo_pkg, swgo_in_if and swgo_out_if.
//
// One sensor request is taken at a time; the block drops ready from acceptance
// until the result is registered. A request runs three sine/cosine evaluations of
// N = min(TRIG_ITERATIONS, 24) steps each on one shared iterative CORDIC, one step
// per cycle, plus eleven products on one shared 35x35 multiplier and the heading
// wrap, which takes off one turn at a time. Ready returns in the same cycle as the
// result appears in the output register. A finished result sits in the output
// register while the next request is taken; if it has still not been taken when
// the next result is due, the block waits.
// speed_scale, time_step and angle_negate sit at byte addresses 0, 4 and 8 of the
// APB port.
module steered_wheel_gyro_odometry #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    swgo_in_if.sink     sensor,
    swgo_out_if.source  odom,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swgo_pkg::*;

    localparam int NIter = (TRIG_ITERATIONS > MaxIter) ? MaxIter : TRIG_ITERATIONS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SL, ST_SR, ST_TRIG_VEL, ST_VX, ST_VY, ST_YAW, ST_WRAP,
        ST_DX, ST_DY, ST_TRIG_POS, ST_WX0, ST_WX1, ST_WY0, ST_WY1,
        ST_TRIG_QUAT, ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7fff;
        else if (v < -20'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // configuration
    logic [15:0] speed_scale_reg;
    logic [15:0] time_step_reg;
    logic        angle_negate_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg  <= 16'd526;
            time_step_reg    <= 16'd3277;
            angle_negate_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SPEED_SCALE:  speed_scale_reg  <= pwdata[15:0];
                REG_TIME_STEP:    time_step_reg    <= pwdata[15:0];
                REG_ANGLE_NEGATE: angle_negate_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SPEED_SCALE:  prdata = {16'd0, speed_scale_reg};
            REG_TIME_STEP:    prdata = {16'd0, time_step_reg};
            REG_ANGLE_NEGATE: prdata = {31'd0, angle_negate_reg};
            default:          prdata = '0;
        endcase
    end

    // datapath state
    state_t                  state_reg;
    logic signed [15:0]      cl_reg, cr_reg, gyro_reg;
    logic signed [16:0]      al_reg, ar_reg;
    logic signed [32:0]      sl_reg;
    logic signed [33:0]      sr_reg;
    logic signed [31:0]      vx_reg, vy_reg;
    logic signed [32:0]      dx_reg, dy_reg;
    logic signed [18:0]      yaw_reg;
    logic signed [15:0]      yaw_accum_reg;
    logic signed [31:0]      world_x_reg, world_y_reg;
    logic signed [ProdW-1:0] acc_reg;
    logic signed [WordW-1:0] x_reg, y_reg, z_reg;
    logic                    neg_reg;
    logic [IterW-1:0]        iter_reg;
    logic                    out_valid_reg;
    logic signed [31:0]      o_vx_reg, o_vy_reg, o_px_reg, o_py_reg;
    logic signed [15:0]      o_hd_reg, o_qz_reg, o_qw_reg;
    logic                    o_rot_reg;

    // shared multiplier
    logic signed [WordW-1:0] mul_a, mul_b;
    logic signed [ProdW-1:0] prod;

    // CORDIC step
    logic signed [WordW-1:0] x_sh, y_sh, x_next, y_next, z_next;
    logic signed [WordW-1:0] cos_v, sin_v;
    logic                    trig_last;

    // CORDIC start angle, folded into +-pi/2
    logic signed [WordW-1:0] trig_ang, fold_z;
    logic                    fold_neg;

    logic signed [17:0]      ang_sum;
    logic signed [34:0]      spd_sum;
    logic                    rot;
    logic signed [38:0]      vel_full;
    logic signed [17:0]      yaw_inc;
    logic signed [39:0]      wx_sum, wy_sum;
    logic signed [ProdW-1:0] wx_acc, wy_acc;
    logic signed [16:0]      al_in, ar_in;

    assign cos_v  = neg_reg ? -x_reg : x_reg;
    assign sin_v  = neg_reg ? -y_reg : y_reg;
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign x_next = (z_reg >= 0) ? x_reg - y_sh : x_reg + y_sh;
    assign y_next = (z_reg >= 0) ? y_reg + x_sh : y_reg - x_sh;
    assign z_next = (z_reg >= 0) ? z_reg - atan_q29(iter_reg) : z_reg + atan_q29(iter_reg);
    assign trig_last = (iter_reg == IterW'(NIter - 1));

    assign ang_sum = 18'(al_reg) + 18'(ar_reg);
    assign spd_sum = 35'(sl_reg) + 35'(sr_reg);
    // opposite strict signs on both angles and speeds; zero never counts
    assign rot = (((al_reg < 0) && (ar_reg > 0)) || ((al_reg > 0) && (ar_reg < 0))) &&
                 (((sl_reg < 0) && (sr_reg > 0)) || ((sl_reg > 0) && (sr_reg < 0)));

    assign al_in = angle_negate_reg ? -17'(sensor.rear_left_angle) : 17'(sensor.rear_left_angle);
    assign ar_in = angle_negate_reg ? -17'(sensor.rear_right_angle)
                                    : 17'(sensor.rear_right_angle);

    // mean steering angle, heading and half heading, all in Q3.29
    always_comb
    begin
        case (state_reg)
            ST_SR:   trig_ang = {{2{ang_sum[17]}}, ang_sum, 15'd0};
            ST_DY:   trig_ang = {yaw_reg, 16'd0};
            default: trig_ang = {yaw_reg[18], yaw_reg, 15'd0};
        endcase
        if (trig_ang > HalfPiQ29)
        begin
            fold_z   = trig_ang - PiQ29;
            fold_neg = 1'b1;
        end
        else if (trig_ang < -HalfPiQ29)
        begin
            fold_z   = trig_ang + PiQ29;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_z   = trig_ang;
            fold_neg = 1'b0;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_SL:   begin mul_a = 35'(cl_reg);   mul_b = 35'(signed'({1'b0, speed_scale_reg})); end
            ST_SR:   begin mul_a = 35'(cr_reg);   mul_b = 35'(signed'({1'b0, speed_scale_reg})); end
            ST_VX:   begin mul_a = spd_sum;       mul_b = cos_v; end
            ST_VY:   begin mul_a = spd_sum;       mul_b = sin_v; end
            ST_YAW:  begin mul_a = 35'(gyro_reg); mul_b = 35'(signed'({1'b0, time_step_reg})); end
            ST_DX:   begin mul_a = 35'(vx_reg);   mul_b = 35'(signed'({1'b0, time_step_reg})); end
            ST_DY:   begin mul_a = 35'(vy_reg);   mul_b = 35'(signed'({1'b0, time_step_reg})); end
            ST_WX0:  begin mul_a = 35'(dx_reg);   mul_b = cos_v; end
            ST_WX1:  begin mul_a = 35'(dy_reg);   mul_b = sin_v; end
            ST_WY0:  begin mul_a = 35'(dx_reg);   mul_b = sin_v; end
            ST_WY1:  begin mul_a = 35'(dy_reg);   mul_b = cos_v; end
            default: begin mul_a = '0;            mul_b = '0; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign vel_full = prod[69:31];
    assign yaw_inc  = prod[32:15];
    assign wx_acc   = acc_reg - prod;
    assign wy_acc   = acc_reg + prod;
    assign wx_sum   = 40'(world_x_reg) + 40'(wx_acc[69:30]);
    assign wy_sum   = 40'(world_y_reg) + 40'(wy_acc[69:30]);

    assign sensor.ready           = (state_reg == ST_IDLE);
    assign odom.valid             = out_valid_reg;
    assign odom.vel_x             = o_vx_reg;
    assign odom.vel_y             = o_vy_reg;
    assign odom.pos_x             = o_px_reg;
    assign odom.pos_y             = o_py_reg;
    assign odom.heading           = o_hd_reg;
    assign odom.quat_z            = o_qz_reg;
    assign odom.quat_w            = o_qw_reg;
    assign odom.in_place_rotation = o_rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            yaw_accum_reg <= '0;
            world_x_reg   <= '0;
            world_y_reg   <= '0;
            iter_reg      <= '0;
        end
        else
        begin
            // in ST_OUT the result register is handled below
            if (out_valid_reg && odom.ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sensor.valid)
                    begin
                        cl_reg    <= sensor.rear_left_count;
                        cr_reg    <= sensor.rear_right_count;
                        gyro_reg  <= sensor.gyro_rate;
                        al_reg    <= al_in;
                        ar_reg    <= ar_in;
                        state_reg <= ST_SL;
                    end
                end
                ST_SL:
                begin
                    sl_reg    <= prod[32:0];
                    state_reg <= ST_SR;
                end
                ST_SR:
                begin
                    sr_reg    <= -prod[33:0];
                    iter_reg  <= '0;
                    x_reg     <= GainQ30;
                    y_reg     <= '0;
                    z_reg     <= fold_z;
                    neg_reg   <= fold_neg;
                    state_reg <= ST_TRIG_VEL;
                end
                ST_TRIG_VEL, ST_TRIG_POS, ST_TRIG_QUAT:
                begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (trig_last)
                    begin
                        case (state_reg)
                            ST_TRIG_VEL: state_reg <= ST_VX;
                            ST_TRIG_POS: state_reg <= ST_WX0;
                            default:     state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_VX:
                begin
                    vx_reg    <= sat32(40'(vel_full));
                    state_reg <= ST_VY;
                end
                ST_VY:
                begin
                    vy_reg    <= sat32(40'(vel_full));
                    state_reg <= ST_YAW;
                end
                ST_YAW:
                begin
                    yaw_reg   <= 19'(yaw_accum_reg) + 19'(yaw_inc);
                    state_reg <= ST_WRAP;
                end
                ST_WRAP:
                begin
                    // one turn per cycle until inside [-pi, pi)
                    if (yaw_reg >= PiQ13)
                        yaw_reg <= yaw_reg - TwoPiQ13;
                    else if (yaw_reg < -PiQ13)
                        yaw_reg <= yaw_reg + TwoPiQ13;
                    else
                    begin
                        yaw_accum_reg <= yaw_reg[15:0];
                        state_reg     <= ST_DX;
                    end
                end
                ST_DX:
                begin
                    dx_reg    <= rot ? '0 : prod[48:16];
                    state_reg <= ST_DY;
                end
                ST_DY:
                begin
                    dy_reg    <= rot ? '0 : prod[48:16];
                    iter_reg  <= '0;
                    x_reg     <= GainQ30;
                    y_reg     <= '0;
                    z_reg     <= fold_z;
                    neg_reg   <= fold_neg;
                    state_reg <= ST_TRIG_POS;
                end
                ST_WX0:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_WX1;
                end
                ST_WX1:
                begin
                    world_x_reg <= sat32(wx_sum);
                    state_reg   <= ST_WY0;
                end
                ST_WY0:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_WY1;
                end
                ST_WY1:
                begin
                    world_y_reg <= sat32(wy_sum);
                    iter_reg    <= '0;
                    x_reg       <= GainQ30;
                    y_reg       <= '0;
                    z_reg       <= fold_z;
                    neg_reg     <= fold_neg;
                    state_reg   <= ST_TRIG_QUAT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || odom.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        o_vx_reg      <= vx_reg;
                        o_vy_reg      <= vy_reg;
                        o_px_reg      <= world_x_reg;
                        o_py_reg      <= world_y_reg;
                        o_hd_reg      <= yaw_accum_reg;
                        o_qz_reg      <= sat16(sin_v[34:15]);
                        o_qw_reg      <= sat16(cos_v[34:15]);
                        o_rot_reg     <= rot;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/swgo_checker.sv]
// Port-level checks on the odometry block, bound to the top level.
// Depends on assert_macros.svh and steered_wheel_gyro_odometry.
`include "assert_macros.svh"

module swgo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] heading
);
    // result held until taken
    `ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid)
    // busy straight after taking a request
    `ASSERT_STD(a_busy_after_req, in_valid && in_ready |=> !in_ready)
    // no result can appear the cycle after a request
    `ASSERT_STD(a_no_instant_result, in_valid && in_ready |=> !$rose(out_valid))
    // heading always wrapped
    `ASSERT_STD(a_heading_range, out_valid |-> (heading >= -16'sd25736) && (heading <= 16'sd25735))
endmodule

bind steered_wheel_gyro_odometry swgo_checker u_swgo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sensor.valid),
    .in_ready  (sensor.ready),
    .out_valid (odom.valid),
    .out_ready (odom.ready),
    .heading   (odom.heading)
);

[test/swgo_tb_pkg.sv]
// Testbench types and the odometry predictor/scoreboard class.
// Depends on swgo_pkg.
package swgo_tb_pkg;
    import swgo_pkg::*;

    typedef struct packed {
        logic signed [15:0] lcount;
        logic signed [15:0] rcount;
        logic signed [15:0] langle;
        logic signed [15:0] rangle;
        logic signed [15:0] gyro;
    } sensor_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               rot;
    } odom_t;

    class odom_scoreboard;
        int          niter;
        logic [15:0] speed_scale = 16'd526;
        logic [15:0] time_step   = 16'd3277;
        logic        angle_neg   = 1'b1;
        longint      wx, wy, yaw;
        odom_t       pending[$];
        int          errors;
        int          checked;
        int          rot_seen;

        function new(int n = 16);
            niter = n;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_SPEED_SCALE:  speed_scale = val[15:0];
                REG_TIME_STEP:    time_step   = val[15:0];
                REG_ANGLE_NEGATE: angle_neg   = val[0];
                default: ;
            endcase
        endfunction

        // arithmetic shift that floors
        function longint fl(longint v, int s);
            return v >>> s;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void sincos(longint ang, output longint c, output longint s);
            longint x, y, z, t;
            bit     flip;
            int     n;
            x = GainQ30; y = 0; z = ang; flip = 0;
            n = niter > MaxIter ? MaxIter : niter;
            if (z > HalfPiQ29) begin z -= PiQ29; flip = 1; end
            else if (z < -HalfPiQ29) begin z += PiQ29; flip = 1; end
            for (int i = 0; i < n; i++) begin
                if (z >= 0) begin
                    t = x - fl(y, i); y = y + fl(x, i); z -= atan_q29(i[4:0]);
                end else begin
                    t = x + fl(y, i); y = y - fl(x, i); z += atan_q29(i[4:0]);
                end
                x = t;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_request(sensor_t in);
            longint sl, sr, al, ar, c, s, vx, vy, dx, dy, hc, hs;
            odom_t  r;
            bit     rot;
            sl = longint'(in.lcount) * longint'(speed_scale);
            sr = -(longint'(in.rcount) * longint'(speed_scale));
            al = in.langle; ar = in.rangle;
            if (angle_neg) begin al = -al; ar = -ar; end
            rot = ((al < 0 && ar > 0) || (al > 0 && ar < 0)) &&
                  ((sl < 0 && sr > 0) || (sl > 0 && sr < 0));
            sincos((al + ar) * 32768, c, s);
            vx = sat(fl((sl + sr) * c, 31), -64'sd2147483648, 64'sd2147483647);
            vy = sat(fl((sl + sr) * s, 31), -64'sd2147483648, 64'sd2147483647);
            yaw = yaw + fl(longint'(in.gyro) * longint'(time_step), 15);
            while (yaw >= PiQ13) yaw -= TwoPiQ13;
            while (yaw < -PiQ13) yaw += TwoPiQ13;
            if (rot) begin dx = 0; dy = 0; end
            else begin
                dx = fl(vx * longint'(time_step), 16);
                dy = fl(vy * longint'(time_step), 16);
            end
            sincos(yaw * 65536, c, s);
            wx = sat(wx + fl(dx * c - dy * s, 30), -64'sd2147483648, 64'sd2147483647);
            wy = sat(wy + fl(dx * s + dy * c, 30), -64'sd2147483648, 64'sd2147483647);
            sincos(yaw * 32768, hc, hs);
            r.vel_x = vx[31:0]; r.vel_y = vy[31:0];
            r.pos_x = wx[31:0]; r.pos_y = wy[31:0];
            r.heading = yaw[15:0];
            r.quat_z = 16'(sat(fl(hs, 15), -32768, 32767));
            r.quat_w = 16'(sat(fl(hc, 15), -32768, 32767));
            r.rot = rot;
            pending.push_back(r);
        endfunction

        function void err(time now, string f, longint e, longint a);
            errors++;
            $display("%0t: %s mismatch expected %0d actual %0d", now, f, e, a);
        endfunction

        function void check_result(odom_t got, time now);
            odom_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", now, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.rot) rot_seen++;
            if (got.vel_x !== e.vel_x) err(now, "vel_x", e.vel_x, got.vel_x);
            if (got.vel_y !== e.vel_y) err(now, "vel_y", e.vel_y, got.vel_y);
            if (got.pos_x !== e.pos_x) err(now, "pos_x", e.pos_x, got.pos_x);
            if (got.pos_y !== e.pos_y) err(now, "pos_y", e.pos_y, got.pos_y);
            if (got.heading !== e.heading) err(now, "heading", e.heading, got.heading);
            if (got.quat_z !== e.quat_z) err(now, "quat_z", e.quat_z, got.quat_z);
            if (got.quat_w !== e.quat_w) err(now, "quat_w", e.quat_w, got.quat_w);
            if (got.rot !== e.rot) err(now, "in_place_rotation", e.rot, got.rot);
        endfunction
    endclass
endpackage

[test/steered_wheel_gyro_odometry_tb.sv]
// Top-level testbench for the odometry block: directed and random sensor requests,
// APB register phases, random stalls on both channels. Depends on swgo_pkg, swgo_tb_pkg.
module steered_wheel_gyro_odometry_tb;
    import swgo_pkg::*;
    import swgo_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    bit          hold_off = 0;

    swgo_in_if  sensor();
    swgo_out_if odom();

    steered_wheel_gyro_odometry #(.TRIG_ITERATIONS(16)) DUT (
        .clk(clk), .rst_n(rst_n), .sensor(sensor.sink), .odom(odom.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    odom_scoreboard sb = new(16);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        sensor.valid = 1'b0;
        sensor.rear_left_count = '0;
        sensor.rear_right_count = '0;
        sensor.rear_left_angle = '0;
        sensor.rear_right_angle = '0;
        sensor.gyro_rate = '0;
        odom.ready = 1'b0;
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays up after acceptance until the next negedge; the block is busy then
    task automatic send(sensor_t s);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            sensor.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sensor.valid <= 1'b1;
        sensor.rear_left_count <= s.lcount;
        sensor.rear_right_count <= s.rcount;
        sensor.rear_left_angle <= s.langle;
        sensor.rear_right_angle <= s.rangle;
        sensor.gyro_rate <= s.gyro;
        @(posedge clk);
        while (!sensor.ready) @(posedge clk);
        sb.note_request(s);
    endtask

    // Receiver with random stalls; hold_off forces a long stretch of back-pressure
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off) odom.ready <= 1'b0;
            else
            begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
                if (gap != 0)
                begin
                    odom.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                odom.ready <= 1'b1;
                @(posedge clk);
                while (!(odom.valid && odom.ready)) @(posedge clk);
                sb.check_result('{odom.vel_x, odom.vel_y, odom.pos_x, odom.pos_y,
                                  odom.heading, odom.quat_z, odom.quat_w,
                                  odom.in_place_rotation}, $time);
            end
        end
    end

    function automatic sensor_t rand_sensor();
        sensor_t s;
        s = sensor_t'(80'({$urandom, $urandom, $urandom}));
        case ($urandom_range(0, 4))
            0: ;
            1:
            begin
                // opposite steering and opposite wheel speeds: spin on the spot
                s.lcount = 16'($urandom_range(1, 3000));
                s.rcount = s.lcount + 16'($urandom_range(0, 50));
                s.langle = 16'($urandom_range(1, 12000));
                s.rangle = -16'($urandom_range(1, 12000));
                if ($urandom_range(0, 1)) begin s.lcount = -s.lcount; s.rcount = -s.rcount; end
            end
            default:
            begin
                s.lcount = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                s.rcount = -s.lcount + $signed(16'($urandom_range(0, 40))) - 16'sd20;
                s.langle = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
                s.rangle = s.langle;
                s.gyro = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            end
        endcase
        return s;
    endfunction

    task automatic drain();
        @(negedge clk);
        sensor.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        logic signed [15:0] ext[4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero handling, most negative angle, wrap
        for (int i = 0; i < 4; i++)
            send('{ext[i], ext[3-i], ext[i], ext[(i+1)%4], ext[i]});
        send('{16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0});
        send('{16'sd100, 16'sd100, 16'sd500, -16'sd500, 16'sd0});
        send('{16'sd100, 16'sd100, 16'sd0, -16'sd500, 16'sd0});
        send('{16'sd0, 16'sd100, 16'sd500, -16'sd500, 16'sd0});
        send('{16'sd1000, -16'sd1000, -16'sd32768, -16'sd32768, 16'sh7fff});
        send('{16'sd1000, -16'sd1000, 16'sd20000, 16'sd20000, 16'sh7fff});
        send('{-16'sd1000, 16'sd1000, -16'sd20000, -16'sd20000, 16'sh8000});
        for (int i = 0; i < 6; i++)
            send('{16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'sh7fff});
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin reg_write(REG_SPEED_SCALE, 32'hffff); reg_write(REG_TIME_STEP, 32'hffff);
                         reg_write(REG_ANGLE_NEGATE, 32'h0); end
                1: begin reg_write(REG_SPEED_SCALE, 32'h0); reg_write(REG_TIME_STEP, 32'h0); end
                2: begin reg_write(REG_SPEED_SCALE, 32'd526); reg_write(REG_TIME_STEP, 32'd3277);
                         reg_write(REG_ANGLE_NEGATE, 32'h1); end
                default:
                begin
                    reg_write(REG_SPEED_SCALE, $urandom_range(0, 65535));
                    reg_write(REG_TIME_STEP, $urandom_range(0, 65535));
                    reg_write(REG_ANGLE_NEGATE, $urandom_range(0, 1));
                end
            endcase
            if (ph == 2)
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int i = 0; i < 150; i++)
                send(rand_sensor());
            drain();
        end

        $display("Checked %0d results (%0d in-place rotations) over 7 register settings.",
                 sb.checked, sb.rot_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
